// ----- rtl/mqt_pkg.sv -----
// package for the quality trimmer: payload types, register indexes, constants
// used by the channel interfaces and all rtl modules
package mqt_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned QualW         = 8;
  localparam int unsigned ReadLenW      = 16;
  localparam int unsigned CutW          = 16;
  localparam int unsigned ScoreW        = 25;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 8;

  localparam logic [QualW-1:0]  PhredOffset   = 8'd33;
  localparam logic [ScoreW-1:0] ScoreMax      = 25'd16777215;
  localparam logic [QualW-1:0]  CutoffReset   = 8'd20;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUALITY_CUTOFF = 8'd0,
    REG_TRIM_DIRECTION = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [QualW-1:0]    quality_char;
    logic [ReadLenW-1:0] read_length;
    logic                last_of_read;
  } item_t;

  typedef struct packed {
    logic [CutW-1:0] cut_position;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [QualW-1:0] quality_cutoff;
    logic             trim_direction;
  } cfg_t;

endpackage

// ----- rtl/mqt_ifs.sv -----
// valid/ready channel interfaces for items, results and register writes
// depends on mqt_pkg
interface mqt_item_if;
  import mqt_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mqt_result_if;
  import mqt_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mqt_cfg_if;
  import mqt_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mott_quality_trimmer.sv -----
// modified mott quality trimmer: input register, score core, result register
// depends on mqt_pkg, mqt_ifs, mqt_cfg_regs, mqt_score_core
//
// One quality character is taken per item and one item per clock cycle is
// sustained outside the stall below; a result is valid once the item that ends
// the read (or has read length 0) has passed the input register and the score
// core into the result register. The score loop (one add, saturate and compare
// against the best score) sets the rate. The result register holds a finished
// cut position while further items keep entering; the input side stalls only
// when that register is still full and the next item also produces a result.
// Configuration must be written by the user with the block idle (not enforced).
module mott_quality_trimmer #(
  parameter int unsigned LENGTH_BITS = mqt_pkg::LengthBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mqt_item_if.sink     item_i,
  mqt_result_if.source result_o,
  mqt_cfg_if.sink      cfg_i
);
  import mqt_pkg::*;

  cfg_t            cfg;
  logic            s1_valid_d, s1_valid_q;
  item_t           s1_item_q;
  logic            res_valid_d, res_valid_q;
  result_t         res_q;
  logic            adv;
  logic            step;
  logic            emit;
  logic [CutW-1:0] cut;
  logic            take;

  assign cfg_i.ready = 1'b1;

  mqt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.payload),
    .cfg_o   (cfg)
  );

  assign adv          = !res_valid_q || result_o.ready;
  assign step         = s1_valid_q && (adv || !emit);
  assign item_i.ready = adv || !emit || !s1_valid_q;
  assign take         = item_i.valid && item_i.ready;

  mqt_score_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .cut_o  (cut)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (step && emit) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_item_q <= item_i.payload;
    end
    if (step && emit) begin
      res_q.cut_position <= cut;
    end
  end

  assign result_o.valid   = res_valid_q;
  assign result_o.payload = res_q;

endmodule

// ----- rtl/mqt_cfg_regs.sv -----
// configuration registers: quality cutoff and trim direction
// depends on mqt_pkg
module mqt_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  mqt_pkg::cfg_wr_t wr_i,
  output mqt_pkg::cfg_t   cfg_o
);
  import mqt_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_i.index)
        REG_QUALITY_CUTOFF: cfg_d.quality_cutoff = wr_i.data;
        REG_TRIM_DIRECTION: cfg_d.trim_direction = wr_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quality_cutoff <= CutoffReset;
      cfg_q.trim_direction <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/mqt_score_core.sv -----
// per-read score state and the mott score update
// depends on mqt_pkg
module mqt_score_core #(
  parameter int unsigned LENGTH_BITS = mqt_pkg::LengthBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  mqt_pkg::item_t          item_i,
  input  mqt_pkg::cfg_t           cfg_i,
  output logic                    emit_o,
  output logic [mqt_pkg::CutW-1:0] cut_o
);
  import mqt_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic signed [ScoreW-1:0] run_d, run_q;
  logic [ScoreW-1:0]        best_d, best_q;
  logic [LENGTH_BITS-1:0]   cut_d, cut_q;
  logic [LENGTH_BITS-1:0]   seen_d, seen_q;
  logic                     stop_d, stop_q;

  logic [31:0]            rlen_ext;
  logic [LENGTH_BITS-1:0] rlen;
  logic                   empty;
  logic                   scored;
  logic [ScoreW:0]        sum;
  logic [ScoreW-1:0]      sat;
  logic [LENGTH_BITS-1:0] cand_cut;
  logic [LENGTH_BITS-1:0] final_cut;
  logic [31:0]            final_ext;

  assign rlen_ext = 32'(item_i.read_length);
  assign rlen     = rlen_ext[LENGTH_BITS-1:0];
  assign empty    = (rlen == '0);
  assign scored   = !stop_q && (seen_q < rlen);

  assign sum = {run_q[ScoreW-1], run_q} + (ScoreW+1)'(cfg_i.quality_cutoff)
             + (ScoreW+1)'(PhredOffset) - (ScoreW+1)'(item_i.quality_char);

  always_comb begin
    if (sum[ScoreW]) begin
      sat = sum[ScoreW-1:0];
    end else if (sum[ScoreW-1]) begin
      sat = ScoreMax;
    end else begin
      sat = sum[ScoreW-1:0];
    end
  end

  assign cand_cut = cfg_i.trim_direction ? (seen_q + 1'b1) : (rlen - 1'b1 - seen_q);

  always_comb begin
    run_d  = run_q;
    best_d = best_q;
    cut_d  = cut_q;
    stop_d = stop_q;
    seen_d = (seen_q != LenMax) ? seen_q + 1'b1 : seen_q;
    if (scored) begin
      run_d = $signed(sat);
      if (sum[ScoreW]) begin
        stop_d = 1'b1;
      end else if (sat > best_q) begin
        best_d = sat;
        cut_d  = cand_cut;
      end
    end
  end

  always_comb begin
    if (best_d != '0) begin
      final_cut = cut_d;
    end else if (cfg_i.trim_direction) begin
      final_cut = '0;
    end else begin
      final_cut = rlen;
    end
  end

  assign final_ext = 32'(final_cut);
  assign emit_o    = empty || item_i.last_of_read;
  assign cut_o     = empty ? '0 : final_ext[CutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      best_q <= '0;
      cut_q  <= '0;
      seen_q <= '0;
      stop_q <= 1'b0;
    end else if (step_i) begin
      if (emit_o) begin
        run_q  <= '0;
        best_q <= '0;
        cut_q  <= '0;
        seen_q <= '0;
        stop_q <= 1'b0;
      end else begin
        run_q  <= run_d;
        best_q <= best_d;
        cut_q  <= cut_d;
        seen_q <= seen_d;
        stop_q <= stop_d;
      end
    end
  end

endmodule

// ----- tb/sv/mqt_cut_checker.sv -----
`timescale 1ns / 1ps
// checker for the quality trimmer: watches the item, result and register channels,
// predicts every cut position and compares it with the block's output
// depends on mqt_pkg and mqt_ifs
module mqt_cut_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  mqt_item_if   item_bus,
  mqt_result_if result_bus,
  mqt_cfg_if    cfg_bus,
  output int    fail_count_o,
  output int    cuts_waiting_o
);

  logic [mqt_pkg::QualW-1:0]    cutoff;
  logic                         forward;
  int                           run_score;
  int                           top_score;
  logic [mqt_pkg::CutW-1:0]     top_cut;
  logic [mqt_pkg::ReadLenW-1:0] base_count;
  bit                           stopped;
  logic [mqt_pkg::CutW-1:0]     cut_q[$];
  logic [mqt_pkg::CutW-1:0]     new_cut;
  logic [mqt_pkg::CutW-1:0]     want_cut;

  function automatic void drop_read();
    run_score  = 0;
    top_score  = 0;
    top_cut    = '0;
    base_count = '0;
    stopped    = 1'b0;
  endfunction

  // one base of the scan; returns 1 when the item ends a read
  function automatic bit trim_step(input mqt_pkg::item_t it,
                                   output logic [mqt_pkg::CutW-1:0] cut);
    int phred;
    cut = '0;
    if (it.read_length == '0) begin
      drop_read();
      return 1'b1;
    end
    if (!stopped && base_count < it.read_length) begin
      phred = int'(it.quality_char) - int'(mqt_pkg::PhredOffset);
      run_score = run_score + int'(cutoff) - phred;
      if (run_score > int'(mqt_pkg::ScoreMax)) run_score = int'(mqt_pkg::ScoreMax);
      if (run_score < 0) begin
        stopped = 1'b1;
      end else if (run_score > top_score) begin
        top_score = run_score;
        if (forward) begin
          top_cut = base_count + 16'd1;
        end else begin
          top_cut = it.read_length - 16'd1 - base_count;
        end
      end
    end
    if (base_count != '1) base_count = base_count + 16'd1;
    if (it.last_of_read) begin
      if (top_score > 0) begin
        cut = top_cut;
      end else begin
        cut = forward ? '0 : it.read_length;
      end
      drop_read();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff  = mqt_pkg::CutoffReset;
      forward = 1'b0;
      drop_read();
      cut_q.delete();
      fail_count_o   <= 0;
      cuts_waiting_o <= 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        if (trim_step(item_bus.payload, new_cut)) cut_q.push_back(new_cut);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (mqt_pkg::cfg_reg_e'(cfg_bus.payload.index))
          mqt_pkg::REG_QUALITY_CUTOFF: cutoff = cfg_bus.payload.data;
          mqt_pkg::REG_TRIM_DIRECTION: forward = cfg_bus.payload.data[0];
          default: ;
        endcase
      end
      if (result_bus.valid && result_bus.ready) begin
        if (cut_q.size() == 0) begin
          $display("%0t: cut_position expected none, got %0d", $time,
                   result_bus.payload.cut_position);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want_cut = cut_q.pop_front();
          if (result_bus.payload.cut_position !== want_cut) begin
            $display("%0t: cut_position expected %0d, got %0d", $time, want_cut,
                     result_bus.payload.cut_position);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      cuts_waiting_o <= cut_q.size();
    end
  end

endmodule

// ----- tb/sv/mott_quality_trimmer_test.sv -----
`timescale 1ns / 1ps
// top of the quality trimmer testbench: clock, reset, register writes, item and
// result traffic with random stalls; verdict from the cut checker
// depends on mqt_pkg, mqt_ifs, mqt_cut_checker and mott_quality_trimmer
module mott_quality_trimmer_test;
  import mqt_pkg::*;

  logic clk;
  logic rst_n;
  bit   calm;
  int   sent;
  int   fail_count;
  int   cuts_waiting;
  logic [QualW-1:0] cur_cutoff;

  mqt_item_if   item_bus ();
  mqt_result_if result_bus ();
  mqt_cfg_if    cfg_bus ();

  mott_quality_trimmer u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  mqt_cut_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .item_bus       (item_bus),
    .result_bus     (result_bus),
    .cfg_bus        (cfg_bus),
    .fail_count_o   (fail_count),
    .cuts_waiting_o (cuts_waiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    result_bus.ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  task automatic push(input logic [QualW-1:0] q, input logic [ReadLenW-1:0] len,
                      input logic last);
    if (!calm && $urandom_range(0, 99) < 9) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.payload <= '{quality_char: q, read_length: len, last_of_read: last};
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (cuts_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [QualW-1:0] lvl, input logic dir);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.payload <= '{index: REG_QUALITY_CUTOFF, data: lvl};
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.payload <= '{index: REG_TRIM_DIRECTION, data: {7'($urandom), dir}};
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    cur_cutoff = lvl;
  endtask

  function automatic logic [QualW-1:0] pick_quality(input int centre);
    int q;
    if ($urandom_range(0, 7) == 0) return QualW'($urandom);
    q = centre + int'($urandom_range(0, 24)) - 12;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return QualW'(q);
  endfunction

  task automatic send_read();
    int n;
    int kind;
    int stop_at;
    int centre;
    logic [ReadLenW-1:0] len;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    centre = 33 + int'(cur_cutoff) + int'($urandom_range(0, 12)) - 6;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      for (int i = 0; i < n; i++) push(pick_quality(centre), ReadLenW'(n), i == n - 1);
    end else if (kind < 80) begin
      // read may end before its length
      stop_at = $urandom_range(1, n);
      for (int i = 0; i < stop_at; i++) begin
        push(pick_quality(centre), ReadLenW'(n), i == stop_at - 1);
      end
    end else if (kind < 84) begin
      // more bases than the length
      stop_at = n + $urandom_range(1, 5);
      for (int i = 0; i < stop_at; i++) begin
        push(pick_quality(centre), ReadLenW'(n), i == stop_at - 1);
      end
    end else if (kind < 88) begin
      // length changes from item to item
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          len = ReadLenW'($urandom_range(1, 65535));
        end else begin
          len = ReadLenW'(n + int'($urandom_range(0, 4)) - 2);
        end
        if (len == '0) len = 16'd1;
        push(pick_quality(centre), len, i == n - 1);
      end
    end else if (kind < 92) begin
      // abandoned by an empty item
      stop_at = $urandom_range(1, n);
      for (int i = 0; i < stop_at; i++) push(pick_quality(centre), ReadLenW'(n), 1'b0);
      push(QualW'($urandom), '0, 1'($urandom));
    end else if (kind < 95) begin
      len = ReadLenW'($urandom_range(1, 65535));
      stop_at = $urandom_range(1, 6);
      for (int i = 0; i < stop_at; i++) push(pick_quality(centre), len, i == stop_at - 1);
    end else begin
      len = ($urandom_range(0, 3) == 0) ? '0 : ReadLenW'($urandom);
      push(QualW'($urandom), len, 1'($urandom));
    end
  endtask

  initial begin
    int target;
    rst_n              = 1'b0;
    calm               = 1'b0;
    sent               = 0;
    cur_cutoff         = CutoffReset;
    item_bus.valid     = 1'b0;
    item_bus.payload   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.payload    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // empty reads
    push(8'd40, 16'd0, 1'b0);
    push(8'd40, 16'd0, 1'b1);
    // single bases at the quality extremes
    push(8'd0, 16'd1, 1'b1);
    push(8'd255, 16'd1, 1'b1);
    // score goes negative on the first base
    push(8'd73, 16'd3, 1'b0);
    push(8'd0, 16'd3, 1'b0);
    push(8'd0, 16'd3, 1'b1);
    push(8'd0, 16'd4, 1'b0);
    push(8'd53, 16'd4, 1'b0);
    push(8'd43, 16'd4, 1'b0);
    push(8'd73, 16'd4, 1'b1);
    // read in progress dropped by an empty item
    push(8'd10, 16'd5, 1'b0);
    push(8'd10, 16'd5, 1'b0);
    push(8'd0, 16'd0, 1'b0);
    push(8'd60, 16'd2, 1'b0);
    push(8'd20, 16'd2, 1'b1);
    // bases past the read length
    push(8'd0, 16'd2, 1'b0);
    push(8'd0, 16'd2, 1'b0);
    push(8'd0, 16'd2, 1'b0);
    push(8'd0, 16'd2, 1'b1);
    // length changes mid-read
    push(8'd10, 16'd3, 1'b0);
    push(8'd10, 16'd3, 1'b0);
    push(8'd10, 16'hFFFF, 1'b1);
    push(8'hAA, 16'hAAAA, 1'b0);
    push(8'h55, 16'h5555, 1'b1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(8'd0, 1'b0);
        1: set_config(8'd255, 1'b1);
        2: set_config(8'd20, 1'b1);
        3: set_config(QualW'($urandom), 1'b0);
        4: set_config(8'd0, 1'b1);
        default: set_config(QualW'($urandom_range(10, 40)), 1'($urandom));
      endcase
      calm = (ph == 2);
      target = sent + 140;
      while (sent < target) send_read();
      settle();
    end

    calm = 1'b0;
    set_config(CutoffReset, 1'b0);
    target = sent + 40;
    while (sent < target) send_read();
    settle();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
